/* src/dsmt_pkg.sv */
package dsmt_pkg;

   localparam int ENTRIES      = 256;
   localparam int PAYLOAD_BITS = 32;
   localparam int IDX_BITS     = $clog2(ENTRIES);
   localparam int CNT_BITS     = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } dsmt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dsmt_sts_type;

endpackage

/* src/dsmt_req_if.sv */
interface dsmt_req_if
   import dsmt_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [PAYLOAD_BITS-1:0] payload;
   logic [IDX_BITS-1:0]     handle;
   logic [IDX_BITS-1:0]     position;

   modport source (output valid, op, payload, handle, position, input ready);
   modport sink   (input valid, op, payload, handle, position, output ready);
endinterface

/* src/dsmt_rsp_if.sv */
interface dsmt_rsp_if
   import dsmt_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [IDX_BITS-1:0]     result_handle;
   logic [PAYLOAD_BITS-1:0] result_payload;
   logic [CNT_BITS-1:0]     live_count;
   logic [1:0]              status;

   modport source (output valid, result_handle, result_payload, live_count, status,
                   input ready);
   modport sink   (input valid, result_handle, result_payload, live_count, status,
                   output ready);
endinterface

/* src/dsmt_ctrl.sv */
module dsmt_ctrl
   import dsmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dsmt_sts_type sts,
   output dsmt_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // Hold until the result register can take the answer.
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* src/dsmt_dp.sv */
module dsmt_dp
   import dsmt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dsmt_cmd_type            cmd,
   output dsmt_sts_type            sts,
   input  logic [1:0]              req_op,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [IDX_BITS-1:0]     req_handle,
   input  logic [IDX_BITS-1:0]     req_position,
   dsmt_rsp_if.source              rsp
);

   // Captured request.
   op_type                  op_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [IDX_BITS-1:0]     hnd_ff;
   logic [IDX_BITS-1:0]     pos_ff;

   // Table memories and their registered read data.
   logic [PAYLOAD_BITS-1:0] dense_mem [ENTRIES];
   logic [IDX_BITS-1:0]     owner_mem [ENTRIES];
   logic [IDX_BITS-1:0]     h2p_mem   [ENTRIES];
   logic [IDX_BITS-1:0]     free_mem  [ENTRIES];

   logic [PAYLOAD_BITS-1:0] dense_rd_ff;
   logic [IDX_BITS-1:0]     owner_rd_ff;
   logic [IDX_BITS-1:0]     h2p_rd_ff;
   logic [IDX_BITS-1:0]     free_rd_ff;

   // Counters and live-handle flags.
   logic [CNT_BITS-1:0] live_ff,   live_in;
   logic [CNT_BITS-1:0] free_ff,   free_in;
   logic [CNT_BITS-1:0] issued_ff, issued_in;
   logic [ENTRIES-1:0]  valid_ff,  valid_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic [IDX_BITS-1:0]     r_handle_ff,  r_handle_in;
   logic [PAYLOAD_BITS-1:0] r_payload_ff, r_payload_in;
   logic [CNT_BITS-1:0]     r_live_ff;
   logic [1:0]              r_status_ff;
   status_type              r_status_in;

   // Read addresses.
   logic [CNT_BITS-1:0] live_dec;
   logic [CNT_BITS-1:0] free_dec;
   logic [IDX_BITS-1:0] dense_raddr;

   // Write ports.
   logic                    dense_we;
   logic [IDX_BITS-1:0]     dense_waddr;
   logic [PAYLOAD_BITS-1:0] dense_wdata;
   logic                    owner_we;
   logic [IDX_BITS-1:0]     owner_waddr;
   logic [IDX_BITS-1:0]     owner_wdata;
   logic                    h2p_we;
   logic [IDX_BITS-1:0]     h2p_waddr;
   logic [IDX_BITS-1:0]     h2p_wdata;
   logic                    free_we;
   logic [IDX_BITS-1:0]     free_waddr;
   logic [IDX_BITS-1:0]     new_handle;
   logic                    handle_ok;

   assign sts.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_op);
         pay_ff <= req_payload;
         hnd_ff <= req_handle;
         pos_ff <= req_position;
      end
   end

   assign live_dec    = live_ff - CNT_BITS'(1);
   assign free_dec    = free_ff - CNT_BITS'(1);
   assign dense_raddr = (op_ff == OP_READ) ? pos_ff : live_dec[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         dense_rd_ff <= dense_mem[dense_raddr];
         owner_rd_ff <= owner_mem[dense_raddr];
         h2p_rd_ff   <= h2p_mem[hnd_ff];
         free_rd_ff  <= free_mem[free_dec[IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dense_we) dense_mem[dense_waddr] <= dense_wdata;
      if (owner_we) owner_mem[owner_waddr] <= owner_wdata;
      if (h2p_we)   h2p_mem[h2p_waddr]     <= h2p_wdata;
      if (free_we)  free_mem[free_waddr]   <= hnd_ff;
   end

   // Commit step: decide the outcome from the read data and the counters.
   always_comb begin
      live_in      = live_ff;
      free_in      = free_ff;
      issued_in    = issued_ff;
      valid_in     = valid_ff;
      r_handle_in  = '0;
      r_payload_in = '0;
      r_status_in  = ST_OK;
      dense_we     = 1'b0;
      dense_waddr  = live_ff[IDX_BITS-1:0];
      dense_wdata  = pay_ff;
      owner_we     = 1'b0;
      owner_waddr  = live_ff[IDX_BITS-1:0];
      owner_wdata  = '0;
      h2p_we       = 1'b0;
      h2p_waddr    = '0;
      h2p_wdata    = live_ff[IDX_BITS-1:0];
      free_we      = 1'b0;
      free_waddr   = free_ff[IDX_BITS-1:0];
      new_handle   = '0;
      handle_ok    = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if (live_ff >= CNT_BITS'(ENTRIES)) begin
               r_status_in = ST_FULL;
            end else begin
               if (free_ff != '0) begin
                  new_handle = free_rd_ff;
                  free_in    = free_dec;
                  handle_ok  = 1'b1;
               end else if (issued_ff < CNT_BITS'(ENTRIES)) begin
                  new_handle = issued_ff[IDX_BITS-1:0];
                  issued_in  = issued_ff + CNT_BITS'(1);
                  handle_ok  = 1'b1;
               end
               if (handle_ok) begin
                  dense_we              = cmd.commit;
                  owner_we              = cmd.commit;
                  owner_wdata           = new_handle;
                  h2p_we                = cmd.commit;
                  h2p_waddr             = new_handle;
                  valid_in[new_handle]  = 1'b1;
                  live_in               = live_ff + CNT_BITS'(1);
                  r_handle_in           = new_handle;
               end else begin
                  r_status_in = ST_FULL;
               end
            end
         end
         OP_REMOVE: begin
            if (!valid_ff[hnd_ff] || live_ff == '0) begin
               r_status_in = ST_BAD;
            end else begin
               // The last dense entry fills the hole and its handle is re-pointed.
               dense_we         = cmd.commit;
               dense_waddr      = h2p_rd_ff;
               dense_wdata      = dense_rd_ff;
               owner_we         = cmd.commit;
               owner_waddr      = h2p_rd_ff;
               owner_wdata      = owner_rd_ff;
               h2p_we           = cmd.commit;
               h2p_waddr        = owner_rd_ff;
               h2p_wdata        = h2p_rd_ff;
               valid_in[hnd_ff] = 1'b0;
               if (free_ff < CNT_BITS'(ENTRIES)) begin
                  free_we = cmd.commit;
                  free_in = free_ff + CNT_BITS'(1);
               end
               live_in = live_dec;
            end
         end
         OP_CLEAR: begin
            valid_in  = '0;
            live_in   = '0;
            free_in   = '0;
            issued_in = '0;
         end
         OP_READ: begin
            if ({1'b0, pos_ff} >= live_ff) begin
               r_status_in = ST_BAD;
            end else begin
               r_handle_in  = owner_rd_ff;
               r_payload_in = dense_rd_ff;
            end
         end
         default: begin
            r_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         free_ff   <= '0;
         issued_ff <= '0;
         valid_ff  <= '0;
      end else if (cmd.commit) begin
         live_ff   <= live_in;
         free_ff   <= free_in;
         issued_ff <= issued_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         r_handle_ff  <= r_handle_in;
         r_payload_ff <= r_payload_in;
         r_live_ff    <= live_in;
         r_status_ff  <= r_status_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_handle  = r_handle_ff;
   assign rsp.result_payload = r_payload_ff;
   assign rsp.live_count     = r_live_ff;
   assign rsp.status         = r_status_ff;

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_BITS'(ENTRIES))
      else $error("live count above table size");

   a_handle_balance: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, live_ff} + {1'b0, free_ff}) == {1'b0, issued_ff})
      else $error("live plus free handles differ from issued handles");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(live_ff))
      else $error("live handle flags disagree with live count");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp.ready))
      else $error("commit would overwrite an unread response");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp.valid)
      else $error("commit did not produce a response");

endmodule

/* src/dense_slot_map_table.sv */
// Channel   Dir  Handshake                Payload
// req_ch    in   valid/ready (sink)       op, payload, handle, position
// rsp_ch    out  valid/ready (source)     result_handle, result_payload, live_count, status
//
// Each request passes through accept, memory lookup and commit into the response
// register. The dependent reads of a remove (indirection, back-reference and dense
// payload) are all issued in the lookup cycle; a new request is taken only after the
// last has committed. Reset is synchronous and clears the counters and the live-handle
// flags at once; there is no clearing pass. A stalled response holds the commit step,
// and the next request is taken while a finished response still waits on rsp_ch.
module dense_slot_map_table
   import dsmt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   dsmt_req_if.sink   req_ch,
   dsmt_rsp_if.source rsp_ch
);

   // Control and datapath talk only through these two structs.
   dsmt_cmd_type cmd;
   dsmt_sts_type sts;

   dsmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the four table memories, the counters, the live-handle
   // flags and the response register.
   dsmt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_ch.op),
      .req_payload  (req_ch.payload),
      .req_handle   (req_ch.handle),
      .req_position (req_ch.position),
      .rsp          (rsp_ch)
   );

endmodule
